[design/max_expression_value_dp_defines.svh]
// Assertion macros for the max_expression_value_dp design.
// Depends on nothing; the asserting module must have clock and reset signals.
`ifndef MAX_EXPRESSION_VALUE_DP_DEFINES_SVH
`define MAX_EXPRESSION_VALUE_DP_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is high.
`define MEV_ASSERT_IMPL(label, cond, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, disabled while reset is high.
`define MEV_ASSERT_NEXT(label, cond, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error("assertion failed");
`else
`define MEV_ASSERT_IMPL(label, cond, cons)
`define MEV_ASSERT_NEXT(label, cond, cons)
`endif
`endif

[design/mev_pkg.sv]
// Shared constants and types for the expression maximum evaluator.
// Used by the channel interfaces, the arithmetic unit and the top level.
package mev_pkg;

   localparam int DIGIT_W            = 4;
   localparam int OP_W               = 2;
   localparam int DATA_W             = 64;
   localparam int HALF_W             = DATA_W / 2;
   localparam int OUT_W              = 52;
   localparam int DEFAULT_MAX_DIGITS = 16;

   localparam logic [OP_W-1:0] OP_ADD = 2'd0;
   localparam logic [OP_W-1:0] OP_SUB = 2'd1;
   localparam logic [OP_W-1:0] OP_MUL = 2'd2;
   localparam logic [OP_W-1:0] OP_RSV = 2'd3;

   localparam logic [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef struct packed {
      logic            start;
      logic [OP_W-1:0] op;
   } alu_ctl_type;

   typedef struct packed {
      logic [DATA_W-1:0] lo;
      logic [DATA_W-1:0] hi;
   } span_type;

endpackage

[design/mev_req_if.sv]
// Input channel: one digit of the expression with the operator after it.
// Depends on mev_pkg for field widths.
interface mev_req_if;
   logic                         valid;
   logic                         ready;
   logic [mev_pkg::DIGIT_W-1:0]  digit;
   logic [mev_pkg::OP_W-1:0]     op_after;
   logic                         is_last;

   modport source (output valid, output digit, output op_after, output is_last,
                   input ready);
   modport sink   (input valid, input digit, input op_after, input is_last,
                   output ready);
endinterface

[design/mev_rsp_if.sv]
// Result channel: the largest value over all parenthesizations.
// Depends on mev_pkg for the result width.
interface mev_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [mev_pkg::OUT_W-1:0]   max_value;

   modport source (output valid, output max_value, input ready);
   modport sink   (input valid, input max_value, output ready);
endinterface

[design/max_expression_value_dp.sv]
// Expression maximum evaluator. Items arrive on req_ch, one digit each with
// the operator that follows it (add, subtract, multiply; code 3 acts as add).
// Digits beyond MAX_DIGITS are dropped. The item with is_last set starts an
// interval evaluation over all spans of the held digits, shortest first,
// keeping the min and max of every span in a span memory with one write
// port and two read ports. The single result on rsp_ch is the largest
// value, saturated to 52 bits signed. Loading writes each digit at once as
// its one-digit span. After the last item of n digits, each of the
// (n^3-n)/6 split points passes four combinations one at a time through
// the shared arithmetic unit, whose multiply reuses one 32x32 multiplier.
// req_ch.ready is low from the last item until the result is loaded into
// the output register. A stalled receiver holds that register; loading
// continues, and a second evaluation waits at its end until the register
// is free. Reset returns the sequencer to idle, empties the digit count
// and drops any pending result; the memories need no clearing.
`include "max_expression_value_dp_defines.svh"
module max_expression_value_dp #(
   parameter int MAX_DIGITS = mev_pkg::DEFAULT_MAX_DIGITS
) (
   input  logic       clock,
   input  logic       reset,
   mev_req_if.sink    req_ch,
   mev_rsp_if.source  rsp_ch
);

   localparam int DW     = mev_pkg::DATA_W;
   localparam int OW     = mev_pkg::OUT_W;
   localparam int IDX_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
   localparam int ADDR_W = 2 * IDX_W;
   localparam int DEPTH  = 2 ** ADDR_W;

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_SPAN    = 4'd2;
   localparam logic [3:0] ST_RD      = 4'd3;
   localparam logic [3:0] ST_ISSUE   = 4'd4;
   localparam logic [3:0] ST_WAIT    = 4'd5;
   localparam logic [3:0] ST_WRITE   = 4'd6;
   localparam logic [3:0] ST_FIN_RD  = 4'd7;
   localparam logic [3:0] ST_FIN_OUT = 4'd8;

   localparam logic [1:0] LAST_COMBO = 2'd3;

   logic [mev_pkg::OP_W-1:0]    op_mem    [MAX_DIGITS];
   mev_pkg::span_type           span_mem  [DEPTH];

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, n_ff, n_in;
   logic [IDX_W-1:0] i_ff, i_in, k_ff, k_in, s_ff, s_in;
   logic [1:0]       t_ff, t_in;
   logic [DW-1:0]    lo_ff, lo_in, hi_ff, hi_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [OW-1:0]    rsp_data_ff, rsp_data_in;

   mev_pkg::span_type  left_rd_ff, right_rd_ff, wr_data;
   logic [ADDR_W-1:0]  left_addr, right_addr, wr_addr;
   logic               wr_en;
   logic [mev_pkg::OP_W-1:0] op_rd_ff;

   logic                      accept, room, digit_we;
   logic [mev_pkg::OP_W-1:0]  op_fixed;
   logic [IDX_W-1:0]          j_idx, last_idx;
   logic [CNT_W-1:0]          i_ext, k_ext, s_ext, j_ext;

   mev_pkg::alu_ctl_type alu_ctl;
   logic [DW-1:0]        alu_a, alu_b, alu_result;
   logic                 alu_done;
   logic [DW-1:0]        fin_val;
   logic                 fin_fits;

   assign accept   = req_ch.valid && req_ch.ready;
   assign room     = cnt_ff < CNT_W'(MAX_DIGITS);
   assign digit_we = accept && room;
   assign op_fixed = (req_ch.op_after == mev_pkg::OP_RSV) ? mev_pkg::OP_ADD
                                                          : req_ch.op_after;

   assign i_ext    = CNT_W'(i_ff);
   assign k_ext    = CNT_W'(k_ff);
   assign s_ext    = CNT_W'(s_ff);
   assign j_ext    = i_ext + k_ext;
   assign j_idx    = IDX_W'(i_ff + k_ff);
   assign last_idx = IDX_W'(n_ff - 1'b1);

   // The final read keeps its address through a stalled output.
   assign left_addr  = (state_ff == ST_FIN_RD || state_ff == ST_FIN_OUT)
                       ? {IDX_W'(0), last_idx} : {i_ff, s_ff};
   assign right_addr = {IDX_W'(s_ff + 1'b1), j_idx};

   // A loaded digit is written at once as the span of that digit alone.
   assign wr_en   = digit_we || (state_ff == ST_WRITE);
   assign wr_addr = (state_ff == ST_IDLE) ? {cnt_ff[IDX_W-1:0], cnt_ff[IDX_W-1:0]}
                                          : {i_ff, j_idx};
   always_comb begin
      if (state_ff == ST_IDLE) begin
         wr_data.lo = DW'(req_ch.digit);
         wr_data.hi = DW'(req_ch.digit);
      end else begin
         wr_data.lo = lo_ff;
         wr_data.hi = hi_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (digit_we) begin
         op_mem[cnt_ff[IDX_W-1:0]] <= op_fixed;
      end
      op_rd_ff <= op_mem[s_ff];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         span_mem[wr_addr] <= wr_data;
      end
      left_rd_ff  <= span_mem[left_addr];
      right_rd_ff <= span_mem[right_addr];
   end

   // Combination order: max/max, max/min, min/max, min/min.
   assign alu_a         = t_ff[1] ? left_rd_ff.lo  : left_rd_ff.hi;
   assign alu_b         = t_ff[0] ? right_rd_ff.lo : right_rd_ff.hi;
   assign alu_ctl.start = (state_ff == ST_ISSUE);
   assign alu_ctl.op    = op_rd_ff;

   mev_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctl    (alu_ctl),
      .a      (alu_a),
      .b      (alu_b),
      .done   (alu_done),
      .result (alu_result)
   );

   assign fin_val  = left_rd_ff.hi;
   assign fin_fits = (&fin_val[DW-1:OW-1]) || !(|fin_val[DW-1:OW-1]);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      s_in         = s_ff;
      t_in         = t_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (room) begin
                  cnt_in = cnt_ff + 1'b1;
               end
               if (req_ch.is_last) begin
                  n_in     = room ? cnt_ff + 1'b1 : cnt_ff;
                  cnt_in   = '0;
                  i_in     = '0;
                  k_in     = IDX_W'(1);
                  state_in = (n_in == CNT_W'(1)) ? ST_FIN_RD : ST_SPAN;
               end
            end
         end
         ST_SPAN: begin
            s_in     = i_ff;
            lo_in    = mev_pkg::VAL_MAX;
            hi_in    = mev_pkg::VAL_MIN;
            state_in = ST_RD;
         end
         ST_RD: begin
            t_in     = '0;
            state_in = ST_ISSUE;
         end
         ST_ISSUE: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (alu_done) begin
               if ($signed(alu_result) < $signed(lo_ff)) begin
                  lo_in = alu_result;
               end
               if ($signed(alu_result) > $signed(hi_ff)) begin
                  hi_in = alu_result;
               end
               if (t_ff != LAST_COMBO) begin
                  t_in     = t_ff + 1'b1;
                  state_in = ST_ISSUE;
               end else if (s_ext + 1'b1 < j_ext) begin
                  s_in     = s_ff + 1'b1;
                  state_in = ST_RD;
               end else begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            if (j_ext + 1'b1 < n_ff) begin
               i_in     = i_ff + 1'b1;
               state_in = ST_SPAN;
            end else if (k_ext + 1'b1 < n_ff) begin
               k_in     = k_ff + 1'b1;
               i_in     = '0;
               state_in = ST_SPAN;
            end else begin
               state_in = ST_FIN_RD;
            end
         end
         ST_FIN_RD: begin
            state_in = ST_FIN_OUT;
         end
         ST_FIN_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               if (fin_fits) begin
                  rsp_data_in = fin_val[OW-1:0];
               end else if (fin_val[DW-1]) begin
                  rsp_data_in = {1'b1, {(OW-1){1'b0}}};
               end else begin
                  rsp_data_in = {1'b0, {(OW-1){1'b1}}};
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff        <= n_in;
      i_ff        <= i_in;
      k_ff        <= k_in;
      s_ff        <= s_in;
      t_ff        <= t_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.max_value = rsp_data_ff;

   // The arithmetic unit only finishes while the sequencer waits for it.
   `MEV_ASSERT_IMPL(a_done_in_wait, alu_done, state_ff == ST_WAIT)
   // The digit count is cleared for the whole evaluation.
   `MEV_ASSERT_IMPL(a_cnt_clear, state_ff != ST_IDLE, cnt_ff == '0)
   // Every span written lies inside the loaded expression.
   `MEV_ASSERT_IMPL(a_span_range, state_ff == ST_WRITE, j_ext < n_ff)
   // A last item always starts evaluation with at least one digit.
   `MEV_ASSERT_NEXT(a_last_starts, accept && req_ch.is_last, state_ff != ST_IDLE && n_ff != '0)
   // Leaving the final state presents the result.
   `MEV_ASSERT_NEXT(a_result_shown, state_ff == ST_FIN_OUT && state_in == ST_IDLE,
                    rsp_ch.valid)

endmodule

[design/mev_alu.sv]
// Shared arithmetic unit: 64-bit wrapping add, subtract and multiply.
// The multiply uses one 32x32 multiplier over phases LL, LH, HL and FIN. Uses mev_pkg.
module mev_alu (
   input  logic                        clock,
   input  logic                        reset,
   input  mev_pkg::alu_ctl_type        ctl,
   input  logic [mev_pkg::DATA_W-1:0]  a,
   input  logic [mev_pkg::DATA_W-1:0]  b,
   output logic                        done,
   output logic [mev_pkg::DATA_W-1:0]  result
);

   localparam int DW = mev_pkg::DATA_W;
   localparam int HW = mev_pkg::HALF_W;

   localparam logic [1:0] PH_LL  = 2'd0;
   localparam logic [1:0] PH_LH  = 2'd1;
   localparam logic [1:0] PH_HL  = 2'd2;
   localparam logic [1:0] PH_FIN = 2'd3;

   logic [DW-1:0]            a_ff, a_in, b_ff, b_in;
   logic [mev_pkg::OP_W-1:0] op_ff, op_in;
   logic [1:0]               phase_ff, phase_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DW-1:0]            acc_ff, acc_in, prod_ff, prod_in;
   logic [DW-1:0]            result_ff, result_in;
   logic [HW-1:0]            mul_x, mul_y;
   logic [DW-1:0]            mul_p;

   // Low product, then the two cross terms; the high-by-high term falls
   // entirely outside the low 64 bits.
   assign mul_x = (phase_ff == PH_HL) ? a_ff[DW-1:HW] : a_ff[HW-1:0];
   assign mul_y = (phase_ff == PH_LH) ? b_ff[DW-1:HW] : b_ff[HW-1:0];
   assign mul_p = DW'(mul_x) * DW'(mul_y);

   always_comb begin
      a_in      = a_ff;
      b_in      = b_ff;
      op_in     = op_ff;
      phase_in  = phase_ff;
      busy_in   = busy_ff;
      acc_in    = acc_ff;
      prod_in   = prod_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      if (ctl.start) begin
         a_in     = a;
         b_in     = b;
         op_in    = ctl.op;
         phase_in = PH_LL;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (op_ff != mev_pkg::OP_MUL) begin
            result_in = (op_ff == mev_pkg::OP_SUB) ? a_ff - b_ff : a_ff + b_ff;
            done_in   = 1'b1;
            busy_in   = 1'b0;
         end else begin
            phase_in = phase_ff + 2'd1;
            unique case (phase_ff)
               PH_LL: begin
                  prod_in = mul_p;
               end
               PH_LH: begin
                  acc_in  = prod_ff;
                  prod_in = mul_p;
               end
               PH_HL: begin
                  acc_in  = acc_ff + {prod_ff[HW-1:0], {HW{1'b0}}};
                  prod_in = mul_p;
               end
               PH_FIN: begin
                  result_in = acc_ff + {prod_ff[HW-1:0], {HW{1'b0}}};
                  done_in   = 1'b1;
                  busy_in   = 1'b0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff      <= a_in;
      b_ff      <= b_in;
      op_ff     <= op_in;
      phase_ff  <= phase_in;
      acc_ff    <= acc_in;
      prod_ff   <= prod_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

[sim/mev_result_checker.sv]
`timescale 1ns / 1ps
// Result checker for the expression maximum evaluator: watches both channels,
// predicts the largest value of each loaded expression and compares results.
// Depends on mev_pkg and the mev_req_if / mev_rsp_if channel interfaces.
module mev_result_checker #(
   parameter int MAX_DIGITS = mev_pkg::DEFAULT_MAX_DIGITS
) (
   input  logic clock,
   input  logic reset,
   mev_req_if   req_mon,
   mev_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   pending_count
);

   localparam int DW = mev_pkg::DATA_W;
   localparam int OW = mev_pkg::OUT_W;

   localparam logic signed [DW-1:0] OUT_TOP = (64'sd1 <<< (OW - 1)) - 64'sd1;
   localparam logic signed [DW-1:0] OUT_BOT = -(64'sd1 <<< (OW - 1));

   logic [mev_pkg::DIGIT_W-1:0] digit_mem [MAX_DIGITS];
   logic [mev_pkg::OP_W-1:0]    op_mem    [MAX_DIGITS];
   int                          held_digits;
   logic signed [OW-1:0]        expected_max_q [$];
   logic signed [OW-1:0]        want;

   // Wrapping 64-bit arithmetic; the reserved code falls through to add.
   function automatic logic signed [DW-1:0] apply_op(input logic signed [DW-1:0] a,
                                                     input logic signed [DW-1:0] b,
                                                     input logic [mev_pkg::OP_W-1:0] op);
      case (op)
         mev_pkg::OP_MUL: return a * b;
         mev_pkg::OP_SUB: return a - b;
         default:         return a + b;
      endcase
   endfunction

   function automatic logic signed [OW-1:0] best_parenthesization(input int n);
      logic signed [DW-1:0] span_lo [MAX_DIGITS][MAX_DIGITS];
      logic signed [DW-1:0] span_hi [MAX_DIGITS][MAX_DIGITS];
      logic signed [DW-1:0] cand [4];
      logic signed [DW-1:0] lo, hi, v;
      int j;
      for (int i = 0; i < n; i++) begin
         span_lo[i][i] = $signed({{(DW-mev_pkg::DIGIT_W){1'b0}}, digit_mem[i]});
         span_hi[i][i] = span_lo[i][i];
      end
      // Spans are built shortest first, so both halves are always ready.
      for (int k = 1; k < n; k++) begin
         for (int i = 0; i + k < n; i++) begin
            j  = i + k;
            lo = mev_pkg::VAL_MAX;
            hi = mev_pkg::VAL_MIN;
            for (int s = i; s < j; s++) begin
               cand[0] = apply_op(span_hi[i][s], span_hi[s+1][j], op_mem[s]);
               cand[1] = apply_op(span_hi[i][s], span_lo[s+1][j], op_mem[s]);
               cand[2] = apply_op(span_lo[i][s], span_hi[s+1][j], op_mem[s]);
               cand[3] = apply_op(span_lo[i][s], span_lo[s+1][j], op_mem[s]);
               for (int t = 0; t < 4; t++) begin
                  if (cand[t] < lo) lo = cand[t];
                  if (cand[t] > hi) hi = cand[t];
               end
            end
            span_lo[i][j] = lo;
            span_hi[i][j] = hi;
         end
      end
      v = span_hi[0][n-1];
      if (v > OUT_TOP) v = OUT_TOP;
      if (v < OUT_BOT) v = OUT_BOT;
      return v[OW-1:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         held_digits = 0;
         expected_max_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_max_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result item %0d with nothing expected",
                           rsp_mon.max_value);
            end else begin
               want = expected_max_q.pop_front();
               if (rsp_mon.max_value !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("max_value mismatch: expected %0d, got %0d",
                              want, rsp_mon.max_value);
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            // Digits past a full store are dropped, the last item included.
            if (held_digits < MAX_DIGITS) begin
               digit_mem[held_digits] = req_mon.digit;
               op_mem[held_digits]    = req_mon.op_after;
               held_digits++;
            end
            if (req_mon.is_last) begin
               expected_max_q = {expected_max_q, best_parenthesization(held_digits)};
               held_digits = 0;
            end
         end
      end
      pending_count = expected_max_q.size();
   end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// Top of the testbench for max_expression_value_dp: clock, reset, stimulus,
// receiver back-pressure and the verdict. Depends on mev_pkg, the channel
// interfaces, the design and mev_result_checker.
module tb;

   localparam int MAX_DIGITS   = mev_pkg::DEFAULT_MAX_DIGITS;
   localparam int RANDOM_ITEMS = 1900;
   localparam int HOLD_PERIOD  = 60000;
   localparam int HOLD_CYCLES  = 6000;

   typedef enum int {
      EXPR_SHORT,
      EXPR_MID,
      EXPR_HUGE,
      EXPR_DEEP_NEG,
      EXPR_OVERLONG
   } expr_kind_type;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   pending_count;
   bit   no_gaps;

   mev_req_if req_ch ();
   mev_rsp_if rsp_ch ();

   max_expression_value_dp #(.MAX_DIGITS(MAX_DIGITS)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   mev_result_checker #(.MAX_DIGITS(MAX_DIGITS)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 120);
   endfunction

   function automatic logic [mev_pkg::DIGIT_W-1:0] any_digit();
      if ($urandom_range(0, 99) < 85) return mev_pkg::DIGIT_W'($urandom_range(0, 9));
      return mev_pkg::DIGIT_W'($urandom_range(10, 15));
   endfunction

   function automatic logic [mev_pkg::OP_W-1:0] any_op();
      if ($urandom_range(0, 9) == 0) return mev_pkg::OP_RSV;
      return mev_pkg::OP_W'($urandom_range(0, 2));
   endfunction

   task automatic offer_digit(input logic [mev_pkg::DIGIT_W-1:0] d,
                              input logic [mev_pkg::OP_W-1:0] op,
                              input logic last);
      int gap;
      gap = no_gaps ? 0 : idle_gap();
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid    <= 1'b1;
      req_ch.digit    <= d;
      req_ch.op_after <= op;
      req_ch.is_last  <= last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Receiver: random ready pattern, with a long hold-off every so often so
   // that a finished result waits and the next expression stalls behind it.
   initial begin
      int cycle_no;
      int hold;
      int run;
      int idle;
      cycle_no = 0;
      hold     = 0;
      run      = 0;
      idle     = 0;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         cycle_no++;
         if (cycle_no % HOLD_PERIOD == HOLD_PERIOD / 30) hold = HOLD_CYCLES;
         if (hold > 0) begin
            rsp_ch.ready <= 1'b0;
            hold--;
         end else begin
            if (run == 0 && idle == 0) begin
               run  = ($urandom_range(0, 9) == 0) ? $urandom_range(300, 800)
                                                  : $urandom_range(1, 30);
               idle = idle_gap();
            end
            if (run > 0) begin
               rsp_ch.ready <= 1'b1;
               run--;
            end else begin
               rsp_ch.ready <= 1'b0;
               idle--;
            end
         end
      end
   end

   initial begin
      #40_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      int                          items;
      int                          expr_no;
      int                          len;
      int                          r;
      expr_kind_type               kind;
      logic [mev_pkg::DIGIT_W-1:0] d;
      logic [mev_pkg::OP_W-1:0]    op;
      logic                        last;

      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.digit    = '0;
      req_ch.op_after = mev_pkg::OP_ADD;
      req_ch.is_last  = 1'b0;
      no_gaps         = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Single digits at both ends, then 9+9, 0-9, 9*9; last operator unused.
      offer_digit(4'd0,  mev_pkg::OP_MUL, 1'b1);
      offer_digit(4'd15, mev_pkg::OP_RSV, 1'b1);
      offer_digit(4'd9,  mev_pkg::OP_ADD, 1'b0);
      offer_digit(4'd9,  mev_pkg::OP_SUB, 1'b1);
      offer_digit(4'd0,  mev_pkg::OP_SUB, 1'b0);
      offer_digit(4'd9,  mev_pkg::OP_ADD, 1'b1);
      offer_digit(4'd9,  mev_pkg::OP_MUL, 1'b0);
      offer_digit(4'd9,  mev_pkg::OP_RSV, 1'b1);
      // Operator code 3 between two digits behaves as add.
      offer_digit(4'd7,  mev_pkg::OP_RSV, 1'b0);
      offer_digit(4'd8,  mev_pkg::OP_MUL, 1'b1);
      offer_digit(4'd1,  mev_pkg::OP_SUB, 1'b0);
      offer_digit(4'd2,  mev_pkg::OP_MUL, 1'b0);
      offer_digit(4'd3,  mev_pkg::OP_ADD, 1'b1);
      offer_digit(4'd15, mev_pkg::OP_SUB, 1'b0);
      offer_digit(4'd15, mev_pkg::OP_MUL, 1'b0);
      offer_digit(4'd14, mev_pkg::OP_SUB, 1'b1);
      offer_digit(4'd5,  mev_pkg::OP_SUB, 1'b0);
      offer_digit(4'd8,  mev_pkg::OP_ADD, 1'b0);
      offer_digit(4'd7,  mev_pkg::OP_MUL, 1'b0);
      offer_digit(4'd4,  mev_pkg::OP_SUB, 1'b0);
      offer_digit(4'd8,  mev_pkg::OP_ADD, 1'b0);
      offer_digit(4'd9,  mev_pkg::OP_MUL, 1'b1);

      // Random expressions, mostly short. The first three are the saturating
      // and overlong shapes so that each is reached early.
      items   = 0;
      expr_no = 0;
      while (items < RANDOM_ITEMS) begin
         if (expr_no == 0) kind = EXPR_HUGE;
         else if (expr_no == 1) kind = EXPR_DEEP_NEG;
         else if (expr_no == 2) kind = EXPR_OVERLONG;
         else begin
            r = $urandom_range(0, 99);
            if (r < 88) kind = EXPR_SHORT;
            else if (r < 94) kind = EXPR_MID;
            else if (r < 96) kind = EXPR_HUGE;
            else if (r < 98) kind = EXPR_DEEP_NEG;
            else kind = EXPR_OVERLONG;
         end
         case (kind)
            EXPR_SHORT:    len = $urandom_range(1, 6);
            EXPR_MID:      len = $urandom_range(7, 12);
            EXPR_OVERLONG: len = $urandom_range(MAX_DIGITS + 1, MAX_DIGITS + 6);
            default:       len = MAX_DIGITS;
         endcase
         no_gaps = ($urandom_range(0, 4) == 0);
         for (int p = 0; p < len; p++) begin
            case (kind)
               EXPR_HUGE: begin
                  d  = mev_pkg::DIGIT_W'($urandom_range(12, 15));
                  op = ($urandom_range(0, 7) == 0) ? mev_pkg::OP_ADD : mev_pkg::OP_MUL;
               end
               EXPR_DEEP_NEG: begin
                  // Zero minus a long product of large digits drives the
                  // maximum below the lower output bound.
                  d  = (p == 0) ? 4'd0 : mev_pkg::DIGIT_W'($urandom_range(12, 15));
                  op = (p == 0) ? mev_pkg::OP_SUB : mev_pkg::OP_MUL;
               end
               default: begin
                  d  = any_digit();
                  op = any_op();
               end
            endcase
            last = (p == len - 1);
            offer_digit(d, op, last);
            if (p < MAX_DIGITS || last) items++;
         end
         expr_no++;
      end

      @(negedge clock);
      req_ch.valid <= 1'b0;
      wait (pending_count == 0);
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
